>>> hdl/hashed_trie_symbol_intern_macros.svh
// ----------------------------------------------------------------------------
// hashed_trie_symbol_intern_macros
// Assertion helpers for the symbol intern block.
// Every use sits in a module that has clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef HASHED_TRIE_SYMBOL_INTERN_MACROS_SVH
`define HASHED_TRIE_SYMBOL_INTERN_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define HTSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle that forces another in the next cycle.
`define HTSI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/htsi_pkg.sv
// ----------------------------------------------------------------------------
// htsi_pkg
// Shared constants and types of the hashed trie symbol intern block.
// ----------------------------------------------------------------------------
package htsi_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SIZE_W        = 13;
  localparam int CHAR_W        = 8;
  localparam int LEN_W         = 8;
  localparam int ENTRY_W       = CHAR_W + IDX_W;

  localparam logic [CHAR_W-1:0] ROOT_MARK = 8'h3F;
  localparam logic [LEN_W-1:0]  LEN_MAX   = 8'hFF;
  localparam logic [SIZE_W-1:0] SIZE_MIN  = 13'd2;
  localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(TABLE_ENTRIES);

  // iterative remainder unit
  localparam int DIV_W      = 2 * CHAR_W;
  localparam int MOD_BPC    = 4;
  localparam int MOD_STEPS  = DIV_W / MOD_BPC;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              first;
    logic [IDX_W-1:0]  sq_mod;   // c*c mod size
    logic [IDX_W-1:0]  c_mod;    // c mod size, the probe stride
  } item_t;

endpackage

>>> hdl/htsi_ram.sv
// ----------------------------------------------------------------------------
// htsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/htsi_mod.sv
// ----------------------------------------------------------------------------
// htsi_mod
// Iterative restoring remainder: dividend mod divisor, a few bits per cycle.
// ----------------------------------------------------------------------------
module htsi_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [htsi_pkg::DIV_W-1:0]    dividend_i,
  input  logic [htsi_pkg::SIZE_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [htsi_pkg::IDX_W-1:0]    rem_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [htsi_pkg::MOD_CNT_W-1:0] cnt_q;
  logic [htsi_pkg::DIV_W-1:0]    div_q, div_d;
  logic [htsi_pkg::IDX_W-1:0]    rem_q, rem_d;
  logic [htsi_pkg::IDX_W:0]      trial;
  logic                          last;

  // remainder stays below divisor <= TABLE_ENTRIES, so IDX_W bits hold it
  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    trial = '0;
    for (int i = 0; i < htsi_pkg::MOD_BPC; i++) begin
      trial = {rem_d, div_d[htsi_pkg::DIV_W-1]};
      div_d = {div_d[htsi_pkg::DIV_W-2:0], 1'b0};
      if (trial >= divisor_i) begin
        trial = trial - divisor_i;
      end
      rem_d = trial[htsi_pkg::IDX_W-1:0];
    end
  end

  assign last = (cnt_q == htsi_pkg::MOD_CNT_W'(htsi_pkg::MOD_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> hdl/htsi_front.sv
// ----------------------------------------------------------------------------
// htsi_front
// Takes characters, works out c*c mod size and c mod size, queues the item.
// ----------------------------------------------------------------------------
module htsi_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_i,
  input  logic [htsi_pkg::CHAR_W-1:0]   character_i,
  input  logic                          first_i,
  input  logic [htsi_pkg::SIZE_W-1:0]   size_i,
  input  logic                          full_i,
  output logic                          busy_o,
  output logic                          push_o,
  output htsi_pkg::item_t               item_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CALC = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [htsi_pkg::CHAR_W-1:0]   char_q;
  logic                          first_q;
  logic                          accept;
  logic [htsi_pkg::DIV_W-1:0]    square;
  logic                          sq_done;
  logic [htsi_pkg::IDX_W-1:0]    sq_rem, c_rem;

  assign accept = req_i && (state_q == F_IDLE);
  assign square = htsi_pkg::DIV_W'(character_i) * htsi_pkg::DIV_W'(character_i);

  htsi_mod u_sq_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (square),
    .divisor_i  (size_i),
    .done_o     (sq_done),
    .rem_o      (sq_rem)
  );

  // same latency as the square unit; its done flag is not needed
  htsi_mod u_c_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (htsi_pkg::DIV_W'(character_i)),
    .divisor_i  (size_i),
    .done_o     (),
    .rem_o      (c_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_CALC;
      end
      F_CALC: begin
        if (sq_done) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q  <= character_i;
      first_q <= first_i;
    end
  end

  assign busy_o           = (state_q != F_IDLE);
  assign push_o           = (state_q == F_PUSH) && !full_i;
  assign item_o.character = char_q;
  assign item_o.first     = first_q;
  assign item_o.sq_mod    = sq_rem;
  assign item_o.c_mod     = c_rem;

endmodule

>>> hdl/htsi_queue.sv
// ----------------------------------------------------------------------------
// htsi_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`include "hashed_trie_symbol_intern_macros.svh"

module htsi_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  htsi_pkg::item_t       item_i,
  input  logic                  pop_i,
  output htsi_pkg::item_t       item_o,
  output logic                  full_o,
  output logic                  empty_o
);

  htsi_pkg::item_t               slot_q [htsi_pkg::QUEUE_DEPTH];
  logic [htsi_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
  logic [htsi_pkg::QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == htsi_pkg::QCNT_W'(htsi_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  `HTSI_ASSERT(a_push_not_full, !(push_i && full_o), "push into full queue")
  `HTSI_ASSERT(a_pop_not_empty, !(pop_i && empty_o), "pop from empty queue")

endmodule

>>> hdl/htsi_back.sv
// ----------------------------------------------------------------------------
// htsi_back
// Probes the trie table, fills empty slots, tracks parent and length.
// Also runs the clearing pass over the table after reset.
// ----------------------------------------------------------------------------
`include "hashed_trie_symbol_intern_macros.svh"

module htsi_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [htsi_pkg::SIZE_W-1:0]   size_i,
  input  logic                          empty_i,
  input  htsi_pkg::item_t               item_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  output logic                          result_valid_o,
  output logic [htsi_pkg::IDX_W-1:0]    node_index_o,
  output logic                          new_entry_o,
  output logic                          overflow_o,
  output logic [htsi_pkg::LEN_W-1:0]    prefix_length_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HOME = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;

  logic [2:0]                     state_q;
  logic [htsi_pkg::IDX_W-1:0]     clr_q;
  logic [htsi_pkg::CHAR_W-1:0]    c_q;
  logic [htsi_pkg::IDX_W-1:0]     cm_q, h_q, home_q, parent_q;
  logic [htsi_pkg::LEN_W-1:0]     len_q;

  logic                           res_valid_q, new_q, ovf_q;
  logic [htsi_pkg::IDX_W-1:0]     node_q;
  logic [htsi_pkg::LEN_W-1:0]     res_len_q;

  logic [htsi_pkg::IDX_W-1:0]     p_eff;
  logic [htsi_pkg::LEN_W-1:0]     len_eff, len_inc;
  logic [htsi_pkg::SIZE_W-1:0]    sum, step, home_sub, step_sub;
  logic                           fast;
  logic [htsi_pkg::IDX_W-1:0]     home_fast, h_next;
  logic                           take, mod_start, mod_done;
  logic [htsi_pkg::IDX_W-1:0]     mod_rem;

  logic                           ram_we;
  logic [htsi_pkg::IDX_W-1:0]     ram_waddr;
  logic [htsi_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic [htsi_pkg::CHAR_W-1:0]    rd_char;
  logic [htsi_pkg::IDX_W-1:0]     rd_par;
  logic                           hit, slot_free;

  // restart by first_of_symbol applies before anything else
  assign p_eff   = item_i.first ? '0 : parent_q;
  assign len_eff = item_i.first ? '0 : len_q;

  // home slot: parent + c*c mod size. Quick when parent < size,
  // otherwise a stale parent from a larger table goes through the mod unit.
  assign sum       = htsi_pkg::SIZE_W'(p_eff) + htsi_pkg::SIZE_W'(item_i.sq_mod);
  assign fast      = (htsi_pkg::SIZE_W'(p_eff) < size_i);
  assign home_sub  = sum - size_i;
  assign home_fast = (sum >= size_i) ? home_sub[htsi_pkg::IDX_W-1:0]
                                     : sum[htsi_pkg::IDX_W-1:0];

  assign step     = htsi_pkg::SIZE_W'(h_q) + htsi_pkg::SIZE_W'(cm_q);
  assign step_sub = step - size_i;
  assign h_next   = (step >= size_i) ? step_sub[htsi_pkg::IDX_W-1:0]
                                     : step[htsi_pkg::IDX_W-1:0];

  assign len_inc = (len_q == htsi_pkg::LEN_MAX) ? len_q : len_q + 1'b1;

  assign take      = (state_q == S_IDLE) && !empty_i;
  assign mod_start = take && (item_i.character != '0) && !fast;

  htsi_mod u_home_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (htsi_pkg::DIV_W'(sum)),
    .divisor_i  (size_i),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign rd_char   = ram_rdata[htsi_pkg::ENTRY_W-1 -: htsi_pkg::CHAR_W];
  assign rd_par    = ram_rdata[htsi_pkg::IDX_W-1:0];
  assign hit       = (rd_char == c_q) && (rd_par == parent_q);
  assign slot_free = (rd_char == '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = h_q;
    ram_wdata = {c_q, parent_q};
    if (state_q == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = (clr_q == '0) ? {htsi_pkg::ROOT_MARK, {htsi_pkg::IDX_W{1'b0}}} : '0;
    end else if (state_q == S_CMP && !hit && slot_free) begin
      ram_we = 1'b1;
    end
  end

  htsi_ram #(
    .WIDTH (htsi_pkg::ENTRY_W),
    .DEPTH (htsi_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == S_RD),
    .raddr_i (h_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      parent_q    <= '0;
      len_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == htsi_pkg::IDX_W'(htsi_pkg::TABLE_ENTRIES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (take) begin
            parent_q <= p_eff;
            len_q    <= len_eff;
            if (item_i.character == '0) begin
              res_valid_q <= 1'b1;
            end else if (fast) begin
              state_q <= S_RD;
            end else begin
              state_q <= S_HOME;
            end
          end
        end
        S_HOME: begin
          if (mod_done) state_q <= S_RD;
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (hit || slot_free) begin
            parent_q    <= h_q;
            len_q       <= len_inc;
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (h_next == home_q) begin
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // probe and result payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (take) begin
          c_q       <= item_i.character;
          cm_q      <= item_i.c_mod;
          h_q       <= home_fast;
          home_q    <= home_fast;
          node_q    <= p_eff;
          new_q     <= 1'b0;
          ovf_q     <= 1'b0;
          res_len_q <= len_eff;
        end
      end
      S_HOME: begin
        if (mod_done) begin
          h_q    <= mod_rem;
          home_q <= mod_rem;
        end
      end
      S_CMP: begin
        if (hit || slot_free) begin
          node_q    <= h_q;
          new_q     <= !hit;
          ovf_q     <= 1'b0;
          res_len_q <= len_inc;
        end else if (h_next == home_q) begin
          node_q    <= parent_q;
          new_q     <= 1'b0;
          ovf_q     <= 1'b1;
          res_len_q <= len_q;
        end else begin
          h_q <= h_next;
        end
      end
      default: begin
      end
    endcase
  end

  assign pop_o           = take;
  assign clearing_o      = (state_q == S_CLR);
  assign result_valid_o  = res_valid_q;
  assign node_index_o    = node_q;
  assign new_entry_o     = new_q;
  assign overflow_o      = ovf_q;
  assign prefix_length_o = res_len_q;

  `HTSI_ASSERT(a_new_xor_ovf, !(res_valid_q && new_q && ovf_q), "new entry and overflow together")
  `HTSI_ASSERT(a_new_has_len, !(res_valid_q && new_q) || (res_len_q != '0), "new entry with zero length")
  `HTSI_ASSERT_NEXT(a_fill_ends, (state_q == S_CMP) && ram_we, (state_q == S_IDLE) && res_valid_q, "fill did not end probe")

endmodule

>>> hdl/hashed_trie_symbol_intern.sv
// ----------------------------------------------------------------------------
// hashed_trie_symbol_intern
// Interns symbol names one character at a time into a hashed character trie.
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+--------------------------
//   command  | in        | start & !busy               | character_i, first_of_symbol_i
//   result   | out       | result_valid_o, one cycle   | node_index_o, new_entry_o,
//            |           |                             | overflow_o, prefix_length_o
//   config   | in        | cfg_valid_i & cfg_ready_o   | cfg_data_i (table_size)
//
// Front: accept, then the remainder units (4 steps, registered done), then the
// queue push, which waits while the queue is full; a command is taken only when
// the front is idle. Back: take; the mod unit when the parent >= table_size;
// per table probe a registered RAM read, then compare; result strobe next cycle.
// Front and back overlap, so the next command is taken while a probe runs.
// After reset the back clears all 4096 table entries with busy high.
// Results cannot be stalled; each strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module hashed_trie_symbol_intern (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [htsi_pkg::CHAR_W-1:0]   character_i,
  input  logic                          first_of_symbol_i,
  output logic                          result_valid_o,
  output logic [htsi_pkg::IDX_W-1:0]    node_index_o,
  output logic                          new_entry_o,
  output logic                          overflow_o,
  output logic [htsi_pkg::LEN_W-1:0]    prefix_length_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [htsi_pkg::SIZE_W-1:0]   cfg_data_i
);

  logic [htsi_pkg::SIZE_W-1:0] table_size_q;
  logic [htsi_pkg::SIZE_W-1:0] size_act;
  logic                        front_busy, clearing;
  logic                        push, pop, q_full, q_empty;
  htsi_pkg::item_t             push_item, head_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= htsi_pkg::SIZE_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      table_size_q <= cfg_data_i;
    end
  end

  // out-of-range sizes are clamped
  assign size_act = (table_size_q < htsi_pkg::SIZE_MIN) ? htsi_pkg::SIZE_MIN :
                    (table_size_q > htsi_pkg::SIZE_MAX) ? htsi_pkg::SIZE_MAX :
                    table_size_q;

  assign busy = front_busy || clearing;

  htsi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (start && !busy),
    .character_i (character_i),
    .first_i     (first_of_symbol_i),
    .size_i      (size_act),
    .full_i      (q_full),
    .busy_o      (front_busy),
    .push_o      (push),
    .item_o      (push_item)
  );

  htsi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  htsi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .size_i          (size_act),
    .empty_i         (q_empty),
    .item_i          (head_item),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .result_valid_o  (result_valid_o),
    .node_index_o    (node_index_o),
    .new_entry_o     (new_entry_o),
    .overflow_o      (overflow_o),
    .prefix_length_o (prefix_length_o)
  );

endmodule

>>> tb/htsi_checker.sv
// ----------------------------------------------------------------------------
// htsi_checker
// Watches the command, config and result channels of the symbol intern block.
// Keeps its own copy of the trie and predicts every result, then compares
// each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module htsi_checker
  import htsi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic              first_i,
  input  logic              res_valid_i,
  input  logic [IDX_W-1:0]  node_i,
  input  logic              fresh_i,
  input  logic              full_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  output int                pending_o,
  output int                fail_count_o
);

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic             fresh;
    logic             full;
    logic [LEN_W-1:0] len;
  } intern_result_t;

  logic [CHAR_W-1:0] node_char   [TABLE_ENTRIES];
  logic [IDX_W-1:0]  node_parent [TABLE_ENTRIES];
  logic [SIZE_W-1:0] size_reg;
  logic [IDX_W-1:0]  parent_q;
  logic [LEN_W-1:0]  len_q;

  intern_result_t    results_q[$];
  intern_result_t    want;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp_val);
    $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
    fail_count_o++;
  endtask

  // one character through the trie; updates the predicted state
  function automatic intern_result_t intern_char(input logic [CHAR_W-1:0] ch,
                                                 input logic first);
    int unsigned    size;
    int unsigned    home;
    int unsigned    h;
    int unsigned    node;
    bit             hit;
    bit             fresh;
    bit             full;
    intern_result_t r;
    size  = size_reg < SIZE_MIN ? SIZE_MIN : (size_reg > SIZE_MAX ? SIZE_MAX : size_reg);
    hit   = 0;
    fresh = 0;
    full  = 0;
    if (first) begin
      parent_q = '0;
      len_q    = '0;
    end
    node = parent_q;
    if (ch != '0) begin
      home = (int'(parent_q) + int'(ch) * int'(ch)) % size;
      h    = home;
      do begin
        if (node_char[h] == ch && node_parent[h] == parent_q) begin
          node = h;
          hit  = 1;
        end else if (node_char[h] == '0) begin
          node_char[h]   = ch;
          node_parent[h] = parent_q;
          node  = h;
          hit   = 1;
          fresh = 1;
        end else begin
          h = (h + ch) % size;
        end
      end while (!hit && h != home);
      if (hit) begin
        parent_q = IDX_W'(node);
        if (len_q < LEN_MAX) len_q++;
      end else begin
        full = 1;
        node = parent_q;
      end
    end
    r.node  = IDX_W'(node);
    r.fresh = fresh;
    r.full  = full;
    r.len   = len_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        node_char[i]   = '0;
        node_parent[i] = '0;
      end
      node_char[0] = ROOT_MARK;
      size_reg     = SIZE_MAX;
      parent_q     = '0;
      len_q        = '0;
      results_q.delete();
      pending_o    = 0;
    end else begin
      if (res_valid_i) begin
        if (results_q.size() == 0) begin
          report_mismatch("result with no transaction pending", node_i, 0);
        end else begin
          want = results_q.pop_front();
          if (node_i !== want.node)   report_mismatch("node_index", node_i, want.node);
          if (fresh_i !== want.fresh) report_mismatch("new_entry", fresh_i, want.fresh);
          if (full_i !== want.full)   report_mismatch("overflow", full_i, want.full);
          if (len_i !== want.len)     report_mismatch("prefix_length", len_i, want.len);
        end
      end
      if (cfg_valid_i && cfg_ready_i) size_reg = cfg_data_i;
      if (start_i && !busy_i) results_q.push_back(intern_char(char_i, first_i));
      pending_o = results_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the symbol intern block: directed corner cases and a long
// name, then phases of random table sizes with dictionary words and noise,
// sent in bursts. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import htsi_pkg::*;

  localparam int NUM_ITEMS = 1050;
  localparam int NUM_WORDS = 8;
  localparam int WORD_MAX  = 12;
  localparam int SETTLE    = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CHAR_W-1:0] cmd_char;
  logic              cmd_first;
  logic              res_valid;
  logic [IDX_W-1:0]  res_node;
  logic              res_fresh;
  logic              res_full;
  logic [LEN_W-1:0]  res_len;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data;
  int                pending;
  int                fail_count;

  logic [CHAR_W-1:0] word_chars [NUM_WORDS][WORD_MAX];
  int                word_len   [NUM_WORDS];
  int                items_sent;
  int                burst_left;

  hashed_trie_symbol_intern uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .character_i       (cmd_char),
    .first_of_symbol_i (cmd_first),
    .result_valid_o    (res_valid),
    .node_index_o      (res_node),
    .new_entry_o       (res_fresh),
    .overflow_o        (res_full),
    .prefix_length_o   (res_len),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data)
  );

  htsi_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .char_i       (cmd_char),
    .first_i      (cmd_first),
    .res_valid_i  (res_valid),
    .node_i       (res_node),
    .fresh_i      (res_fresh),
    .full_i       (res_full),
    .len_i        (res_len),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  // one character; bursts of random length with random gaps between them
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic first);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    cmd_char  <= ch;
    cmd_first <= first;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    items_sent++;
  endtask

  // hold off until every pending result has come back
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input int w);
    for (int i = 0; i < word_len[w]; i++) send_char(word_chars[w][i], i == 0);
  endtask

  initial begin
    int phase_len;
    int phase_end;
    int sel;
    int n;
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_char   = '0;
    cmd_first  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    items_sent = 0;
    burst_left = 0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      word_len[w] = $urandom_range(1, WORD_MAX);
      for (int i = 0; i < WORD_MAX; i++) word_chars[w][i] = CHAR_W'($urandom_range(1, 255));
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // tiny table: root marker hit at home slot, wrap, full table
    write_size(13'd3);
    send_char(ROOT_MARK, 1'b1);
    send_char(ROOT_MARK, 1'b0);
    send_char(8'd1, 1'b1);
    send_char(8'd255, 1'b0);
    send_char(8'd2, 1'b1);
    send_char(8'd2, 1'b1);
    send_char(8'd5, 1'b1);

    // above the maximum acts as the full table; extremes and reuse
    write_size(13'h1FFF);
    send_char(8'd255, 1'b1);
    send_char(8'd1, 1'b0);
    send_char(8'd128, 1'b0);
    send_char(ROOT_MARK, 1'b0);
    send_char(8'h41, 1'b1);
    send_char(8'h42, 1'b0);
    send_char(8'h41, 1'b1);
    send_char(8'h42, 1'b0);
    send_char(8'h7F, 1'b0);

    // shrink with the parent left beyond the new size, then root marker by probing
    write_size(13'd0);
    send_char(8'd7, 1'b0);
    send_char(ROOT_MARK, 1'b1);
    write_size(13'd1);
    send_char(8'd1, 1'b1);
    send_char(8'd3, 1'b0);

    // long name at full size so the length saturates
    write_size(SIZE_MAX);
    send_char(CHAR_W'($urandom_range(1, 255)), 1'b1);
    repeat (269) send_char(CHAR_W'($urandom_range(1, 255)), 1'b0);

    while (items_sent < NUM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)       write_size(SIZE_W'($urandom_range(2, 16)));
      else if (sel < 7)  write_size(SIZE_W'($urandom_range(17, 300)));
      else if (sel == 7) write_size(SIZE_MAX);
      else if (sel == 8) write_size(SIZE_W'($urandom_range(4097, 8191)));
      else               write_size(SIZE_W'($urandom_range(0, 1)));
      phase_len = $urandom_range(20, 80);
      phase_end = items_sent + phase_len;
      while (items_sent < phase_end && items_sent < NUM_ITEMS) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          send_char(CHAR_W'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
        end else begin
          send_word($urandom_range(0, NUM_WORDS - 1));
          if (sel > 6) begin
            n = $urandom_range(1, 4);
            repeat (n) send_char(CHAR_W'($urandom_range(1, 255)), 1'b0);
          end
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
